@@ design/siu_pkg.sv @@
// Shared types, widths and codes for the segment intersection unit.
// No dependencies; every design file imports this package.
`timescale 1ns / 1ps

package siu_pkg;

  localparam int CW      = 24;
  localparam int FB      = 24;
  localparam int PW      = 32;
  localparam int TW      = 24;
  localparam int EW      = 32;
  localparam int DW      = CW + 1;
  localparam int NW      = 2 * DW + 1;
  localparam int NNW     = NW + FB + 1;
  localparam int DIV_LAT = PW + 1;

  typedef enum logic [1:0] {
    CMD_ON     = 2'd0,
    CMD_NEAR   = 2'd1,
    CMD_ANY    = 2'd2,
    CMD_WITHIN = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OFF      = 2'd2,
    ST_TOUCH    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic signed [CW-1:0] p1_x;
    logic signed [CW-1:0] p1_y;
    logic signed [CW-1:0] q1_x;
    logic signed [CW-1:0] q1_y;
    logic signed [CW-1:0] p2_x;
    logic signed [CW-1:0] p2_y;
    logic signed [CW-1:0] q2_x;
    logic signed [CW-1:0] q2_y;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [PW-1:0] param_s;
    logic signed [PW-1:0] param_t;
  } out_item_t;

endpackage

@@ design/siu_div.sv @@
// Pipelined restoring divider for one intersection parameter: an overflow stage, then one quotient bit per stage.
// Produces a rounded, signed and saturated Q8.24 value; depends on siu_pkg.
`timescale 1ns / 1ps

module siu_div import siu_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NNW-1:0]       num,
  input  logic [NW-1:0]        den,
  input  logic                 neg,
  output logic signed [PW-1:0] quot
);

  localparam logic [PW-1:0] MAXP = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] MINN = {1'b1, {(PW-1){1'b0}}};

  logic [NW-1:0] rem  [DIV_LAT];
  logic [NW-1:0] dq   [DIV_LAT];
  logic [PW-1:0] low  [DIV_LAT];
  logic [PW-1:0] qacc [DIV_LAT];
  logic          negq [DIV_LAT];
  logic          ovf  [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= NW'(num[NNW-1:PW]);
      low[0]  <= num[PW-1:0];
      qacc[0] <= '0;
      dq[0]   <= den;
      negq[0] <= neg;
      ovf[0]  <= NW'(num[NNW-1:PW]) >= den;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [NW:0] trial;
    logic [NW:0] diff;
    logic        ge;
    assign trial = {rem[k-1], low[k-1][PW-1]};
    assign diff  = trial - {1'b0, dq[k-1]};
    assign ge    = trial >= {1'b0, dq[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? diff[NW-1:0] : trial[NW-1:0];
        qacc[k] <= {qacc[k-1][PW-2:0], ge};
        low[k]  <= {low[k-1][PW-2:0], 1'b0};
        dq[k]   <= dq[k-1];
        negq[k] <= negq[k-1];
        ovf[k]  <= ovf[k-1];
      end
    end
  end

  always_comb begin
    if (negq[DIV_LAT-1]) begin
      if (ovf[DIV_LAT-1] || qacc[DIV_LAT-1] > MINN) begin
        quot = $signed(MINN);
      end else begin
        quot = $signed(~qacc[DIV_LAT-1] + PW'(1));
      end
    end else begin
      if (ovf[DIV_LAT-1] || qacc[DIV_LAT-1][PW-1]) begin
        quot = $signed(MAXP);
      end else begin
        quot = $signed(qacc[DIV_LAT-1]);
      end
    end
  end

endmodule

@@ design/segment_intersection_unit_core.sv @@
// Top level of the segment intersection unit: input pipeline, two dividers, checks and point.
// Depends on siu_pkg and siu_div.
`timescale 1ns / 1ps

// The block takes one segment pair per cycle and returns one result per item, with a new
// item accepted in every cycle while results are taken. Each item passes through four front
// stages (differences, products, determinant, magnitudes), the 33-stage restoring divider
// (an overflow check, then one quotient bit of s and of t per stage), and three back stages
// (mode checks, point product, rounding and saturation). A stalled output holds the whole
// pipeline. Configuration writes take effect at once and are meant for times when no item
// is in flight.
module segment_intersection_unit_core import siu_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [EW-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {
    CFG_DET_EPS  = 2'd0,
    CFG_ON_TOL   = 2'd1,
    CFG_NEAR_LIM = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic                 par;
    logic signed [CW-1:0] p1x;
    logic signed [CW-1:0] p1y;
    logic signed [DW-1:0] d1x;
    logic signed [DW-1:0] d1y;
  } side_t;

  localparam int SX = PW + 2;
  localparam int MW = PW + DW;
  localparam int M2 = 2 * DW;
  localparam logic signed [SX-1:0] ONE     = SX'(1) << FB;
  localparam logic signed [MW-1:0] HALF    = MW'(1) << (FB - 1);
  localparam logic signed [MW:0]   HIT_MAX = (MW+1)'(2**(CW-1) - 1);
  localparam logic signed [MW:0]   HIT_MIN = -HIT_MAX - (MW+1)'(1);

  logic [EW-1:0] det_eps;
  logic [TW-1:0] on_tol;
  logic [TW-1:0] near_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_eps  <= '0;
      on_tol   <= TW'(2);
      near_lim <= TW'(838861);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DET_EPS:  det_eps  <= cfg_wdata;
        CFG_ON_TOL:   on_tol   <= cfg_wdata[TW-1:0];
        CFG_NEAR_LIM: near_lim <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic v1, v2, v3, v4, vchk, vmul, vout;
  logic [DIV_LAT-1:0] vdiv;

  assign en        = !vout || out_ready;
  assign in_ready  = en;
  assign out_valid = vout;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      vdiv <= '0;
      vchk <= 1'b0;
      vmul <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      vdiv <= {vdiv[DIV_LAT-2:0], v4};
      vchk <= vdiv[DIV_LAT-1];
      vmul <= vchk;
      vout <= vmul;
    end
  end

  function automatic logic signed [DW-1:0] sdiff(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  cmd_t                 cmd1;
  logic signed [CW-1:0] p1x1, p1y1;
  logic signed [DW-1:0] d1x1, d1y1, d2x1, d2y1, wx1, wy1;

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= in_data.cmd;
      p1x1 <= in_data.p1_x;
      p1y1 <= in_data.p1_y;
      d1x1 <= sdiff(in_data.q1_x, in_data.p1_x);
      d1y1 <= sdiff(in_data.q1_y, in_data.p1_y);
      d2x1 <= sdiff(in_data.q2_x, in_data.p2_x);
      d2y1 <= sdiff(in_data.q2_y, in_data.p2_y);
      wx1  <= sdiff(in_data.p2_x, in_data.p1_x);
      wy1  <= sdiff(in_data.p2_y, in_data.p1_y);
    end
  end

  cmd_t                 cmd2;
  logic signed [CW-1:0] p1x2, p1y2;
  logic signed [DW-1:0] d1x2, d1y2;
  logic signed [M2-1:0] ma, mb, mc, md, me, mf;

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2 <= cmd1;
      p1x2 <= p1x1;
      p1y2 <= p1y1;
      d1x2 <= d1x1;
      d1y2 <= d1y1;
      ma   <= M2'(d1x1) * M2'(d2y1);
      mb   <= M2'(d1y1) * M2'(d2x1);
      mc   <= M2'(wx1) * M2'(d2y1);
      md   <= M2'(wy1) * M2'(d2x1);
      me   <= M2'(wx1) * M2'(d1y1);
      mf   <= M2'(wy1) * M2'(d1x1);
    end
  end

  cmd_t                 cmd3;
  logic signed [CW-1:0] p1x3, p1y3;
  logic signed [DW-1:0] d1x3, d1y3;
  logic signed [NW-1:0] det3, ns3, nt3;

  always_ff @(posedge clk) begin
    if (en) begin
      cmd3 <= cmd2;
      p1x3 <= p1x2;
      p1y3 <= p1y2;
      d1x3 <= d1x2;
      d1y3 <= d1y2;
      det3 <= NW'(ma) - NW'(mb);
      ns3  <= NW'(mc) - NW'(md);
      nt3  <= NW'(me) - NW'(mf);
    end
  end

  logic [NW-1:0] adet_c, ans_c, ant_c;
  assign adet_c = det3[NW-1] ? NW'(-det3) : NW'(det3);
  assign ans_c  = ns3[NW-1] ? NW'(-ns3) : NW'(ns3);
  assign ant_c  = nt3[NW-1] ? NW'(-nt3) : NW'(nt3);

  side_t          side4;
  logic [NW-1:0]  adet4;
  logic [NNW-1:0] ns4, nt4;
  logic           negs4, negt4;

  always_ff @(posedge clk) begin
    if (en) begin
      side4.cmd <= cmd3;
      side4.par <= adet_c <= NW'(det_eps);
      side4.p1x <= p1x3;
      side4.p1y <= p1y3;
      side4.d1x <= d1x3;
      side4.d1y <= d1y3;
      adet4     <= adet_c;
      ns4       <= (NNW'(ans_c) << FB) + NNW'(adet_c >> 1);
      nt4       <= (NNW'(ant_c) << FB) + NNW'(adet_c >> 1);
      negs4     <= ns3[NW-1] ^ det3[NW-1];
      negt4     <= nt3[NW-1] ^ det3[NW-1];
    end
  end

  logic signed [PW-1:0] s_div, t_div;

  siu_div u_div_s (
    .clk  (clk),
    .en   (en),
    .num  (ns4),
    .den  (adet4),
    .neg  (negs4),
    .quot (s_div)
  );

  siu_div u_div_t (
    .clk  (clk),
    .en   (en),
    .num  (nt4),
    .den  (adet4),
    .neg  (negt4),
    .quot (t_div)
  );

  side_t side_q [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side4;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  function automatic logic in_range(input logic signed [PW-1:0] v, input logic [TW-1:0] sl);
    logic signed [SX-1:0] ve;
    logic signed [SX-1:0] se;
    begin
      ve = SX'(v);
      se = $signed(SX'(sl));
      return (ve >= -se) && (ve <= ONE + se);
    end
  endfunction

  function automatic logic at_end(input logic signed [PW-1:0] v, input logic [TW-1:0] tl);
    logic signed [SX-1:0] ve;
    logic signed [SX-1:0] te;
    begin
      ve = SX'(v);
      te = $signed(SX'(tl));
      return (ve <= te) || ((ONE - ve) <= te);
    end
  endfunction

  side_t   dside;
  status_t st_c;
  assign dside = side_q[DIV_LAT-1];

  always_comb begin
    st_c = ST_FOUND;
    if (dside.par) begin
      st_c = ST_PARALLEL;
    end else begin
      case (dside.cmd)
        CMD_ON, CMD_WITHIN: begin
          if (!in_range(s_div, on_tol) || !in_range(t_div, on_tol)) begin
            st_c = ST_OFF;
          end else if (dside.cmd == CMD_WITHIN && at_end(s_div, on_tol) &&
                       at_end(t_div, on_tol)) begin
            st_c = ST_TOUCH;
          end
        end
        CMD_NEAR: begin
          if (!in_range(s_div, near_lim) || !in_range(t_div, near_lim)) begin
            st_c = ST_OFF;
          end
        end
        default: st_c = ST_FOUND;
      endcase
    end
  end

  status_t              st5;
  logic signed [PW-1:0] s5, t5;
  logic signed [CW-1:0] p1x5, p1y5;
  logic signed [DW-1:0] d1x5, d1y5;

  always_ff @(posedge clk) begin
    if (en) begin
      st5  <= st_c;
      s5   <= s_div;
      t5   <= t_div;
      p1x5 <= dside.p1x;
      p1y5 <= dside.p1y;
      d1x5 <= dside.d1x;
      d1y5 <= dside.d1y;
    end
  end

  status_t              st6;
  logic signed [PW-1:0] s6, t6;
  logic signed [CW-1:0] p1x6, p1y6;
  logic signed [MW-1:0] px6, py6;

  always_ff @(posedge clk) begin
    if (en) begin
      st6  <= st5;
      s6   <= s5;
      t6   <= t5;
      p1x6 <= p1x5;
      p1y6 <= p1y5;
      px6  <= MW'(s5) * MW'(d1x5);
      py6  <= MW'(s5) * MW'(d1y5);
    end
  end

  function automatic logic signed [CW-1:0] place(input logic signed [CW-1:0] base,
                                                 input logic signed [MW-1:0] prod);
    logic signed [MW-1:0] sh;
    logic signed [MW:0]   sum;
    begin
      sh  = (prod + HALF) >>> FB;
      sum = (MW+1)'(sh) + (MW+1)'(base);
      if (sum > HIT_MAX) begin
        sum = HIT_MAX;
      end else if (sum < HIT_MIN) begin
        sum = HIT_MIN;
      end
      return sum[CW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.status  <= st6;
      out_data.hit_x   <= (st6 == ST_FOUND) ? place(p1x6, px6) : '0;
      out_data.hit_y   <= (st6 == ST_FOUND) ? place(p1y6, py6) : '0;
      out_data.param_s <= (st6 == ST_PARALLEL) ? '0 : s6;
      out_data.param_t <= (st6 == ST_PARALLEL) ? '0 : t6;
    end
  end

`ifndef SYNTHESIS
  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_FOUND |-> out_data.hit_x == '0 && out_data.hit_y == '0)
    else $error("Hit point is not zero for an item that was not found.");

  a_par_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_PARALLEL |->
      out_data.param_s == '0 && out_data.param_t == '0)
    else $error("Parameters are not zero for a parallel item.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vmul && !en |=> vmul)
    else $error("Pipeline lost an item while the output was stalled.");
`endif

endmodule
